>>> rtl/stepper_position_conductor_assert.svh
// Assertion macros for the stepper position conductor.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef STEPPER_POSITION_CONDUCTOR_ASSERT_SVH
`define STEPPER_POSITION_CONDUCTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spc_pkg.sv
// Shared types, widths and codes for the stepper position conductor.
// Depends on nothing; each RTL module file refers to it by scoped names.
`default_nettype none

package spc_pkg;

    // Encoder and target positions use the low POSITION_BITS bits, sign-extended.
    localparam int POSITION_BITS = 32;
    localparam int POS_W         = 32;
    localparam int POS_SHIFT     = POS_W - POSITION_BITS;
    localparam int LIMIT_W       = 31;
    localparam int TIMEOUT_W     = 32;
    localparam int DATA_W        = 32;
    // Wide enough for a path difference plus or minus a full turn.
    localparam int DIFF_W        = 34;

    localparam logic [LIMIT_W-1:0] MAX_POS_RESET = LIMIT_W'(32767);

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_TARGET = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RPT_STOP = 2'd0,
        RPT_UP   = 2'd1,
        RPT_DOWN = 2'd2,
        RPT_RSVD = 2'd3
    } report_t;

    typedef enum logic [1:0] {
        CFG_MIN_POS    = 2'd0,
        CFG_MAX_POS    = 2'd1,
        CFG_MULTI_TURN = 2'd2,
        CFG_TIMEOUT_MS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]   min_pos;
        logic [LIMIT_W-1:0]   max_pos;
        logic                 multi_turn;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic moving;
        logic timer_saturated;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/stepper_position_conductor.sv
// Stepper position conductor. A result reaches m_valid through the input register, then the
// result register. Throughput: one transaction per cycle; s_ready drops only while a held
// result waits on m_ready with a second transaction already registered. Configuration
// writes are always accepted, since cfg_ready is tied high.
// Synchronous active-low reset clears motion state, pipeline valids and restores
// register defaults (min 0, max 32767, linear mode, timeout disabled).
`default_nettype none

`include "stepper_position_conductor_assert.svh"

module stepper_position_conductor (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_action,
    input  wire logic [spc_pkg::POS_W-1:0]   s_position,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_report,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [spc_pkg::DATA_W-1:0]  cfg_data
);

    spc_pkg::cfg_t    cfg;
    spc_pkg::status_t status;

    logic                       in_valid_reg, in_valid_next;
    logic [1:0]                 in_action_reg;
    logic [spc_pkg::POS_W-1:0]  in_position_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 out_report_reg;
    logic                       advance;
    logic                       res_valid;
    logic [1:0]                 res_report;

    assign cfg_ready = 1'b1;

    spc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The registered transaction is resolved once the result register can take its outcome.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    spc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (advance),
        .action     (in_action_reg),
        .position   (in_position_reg),
        .res_valid  (res_valid),
        .res_report (res_report),
        .status     (status)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg   <= s_action;
            in_position_reg <= s_position;
        end
        if (advance && res_valid) begin
            out_report_reg <= res_report;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_report = out_report_reg;

    `SPC_ASSERT_NOW(a_report_code, m_valid, m_report != spc_pkg::RPT_RSVD, "reserved report code")
    `SPC_ASSERT_NOW(a_ready_stall, !s_ready, m_valid && !m_ready && in_valid_reg, "input stalled without a held result")
    `SPC_ASSERT_NEXT(a_run_sets_moving, advance && res_valid && res_report != spc_pkg::RPT_STOP, status.moving, "run report without motion")
    `SPC_ASSERT_NEXT(a_stop_clears, advance && res_valid && res_report == spc_pkg::RPT_STOP, !status.moving && !status.timer_saturated, "stop report left motion state")

endmodule

`default_nettype wire

>>> rtl/spc_cfg_regs.sv
// Configuration register file for the stepper position conductor.
// Depends on spc_pkg for the register layout and index codes.
`default_nettype none

module spc_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [1:0]                 wr_index,
    input  wire logic [spc_pkg::DATA_W-1:0] wr_data,
    output spc_pkg::cfg_t                   cfg
);

    spc_pkg::cfg_t cfg_reg;
    spc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (spc_pkg::cfg_index_t'(wr_index))
                spc_pkg::CFG_MIN_POS:    cfg_next.min_pos = wr_data[spc_pkg::LIMIT_W-1:0];
                spc_pkg::CFG_MAX_POS:    cfg_next.max_pos = wr_data[spc_pkg::LIMIT_W-1:0];
                spc_pkg::CFG_MULTI_TURN: cfg_next.multi_turn = wr_data[0];
                spc_pkg::CFG_TIMEOUT_MS: cfg_next.timeout_ms = wr_data[spc_pkg::TIMEOUT_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pos    <= '0;
            cfg_reg.max_pos    <= spc_pkg::MAX_POS_RESET;
            cfg_reg.multi_turn <= 1'b0;
            cfg_reg.timeout_ms <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/spc_core.sv
// Decision logic and motion state of the stepper position conductor.
// Depends on spc_pkg; one transaction is resolved per cycle in which step is high.
`default_nettype none

module spc_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire spc_pkg::cfg_t             cfg,
    input  wire logic                      step,
    input  wire logic [1:0]                action,
    input  wire logic [spc_pkg::POS_W-1:0] position,
    output logic                           res_valid,
    output logic [1:0]                     res_report,
    output spc_pkg::status_t               status
);

    localparam int DW = spc_pkg::DIFF_W;
    localparam int PW = spc_pkg::POS_W;

    logic signed [PW-1:0]                current_pos_reg, current_pos_next;
    logic signed [PW-1:0]                target_pos_reg, target_pos_next;
    logic                                moving_reg, moving_next;
    logic [spc_pkg::TIMEOUT_W-1:0]       elapsed_ms_reg, elapsed_ms_next;

    logic [PW-1:0]         pos_shl;
    logic signed [PW-1:0]  pos_ext;
    logic signed [DW-1:0]  pos_w, lo_w, hi_w, clamped, cur_w;
    logic signed [DW-1:0]  direct, turn, wrapped, abs_direct, abs_wrapped;
    logic                  use_wrap, go_up, timer_full, timed_out;
    logic [spc_pkg::TIMEOUT_W-1:0] elapsed_inc;

    // Sign-extend the used low bits of the position field.
    assign pos_shl = position << spc_pkg::POS_SHIFT;
    assign pos_ext = $signed(pos_shl) >>> spc_pkg::POS_SHIFT;

    assign pos_w = DW'(pos_ext);
    assign lo_w  = $signed({{(DW-spc_pkg::LIMIT_W){1'b0}}, cfg.min_pos});
    assign hi_w  = $signed({{(DW-spc_pkg::LIMIT_W){1'b0}}, cfg.max_pos});
    assign cur_w = DW'(current_pos_reg);

    // Below min wins over above max when the limits are inverted.
    assign clamped = (pos_w < lo_w) ? lo_w : ((pos_w > hi_w) ? hi_w : pos_w);

    assign direct      = clamped - cur_w;
    assign turn        = hi_w - lo_w;
    assign wrapped     = (direct > 0) ? (direct - turn) : (direct + turn);
    assign abs_direct  = (direct < 0) ? -direct : direct;
    assign abs_wrapped = (wrapped < 0) ? -wrapped : wrapped;
    assign use_wrap    = cfg.multi_turn && (turn > 0) && (abs_wrapped < abs_direct);
    assign go_up       = use_wrap ? (wrapped > 0) : (direct > 0);

    assign timer_full  = &elapsed_ms_reg;
    assign elapsed_inc = timer_full ? elapsed_ms_reg : elapsed_ms_reg + 1'b1;
    assign timed_out   = (cfg.timeout_ms != '0) && (elapsed_inc > cfg.timeout_ms);

    always_comb begin
        current_pos_next = current_pos_reg;
        target_pos_next  = target_pos_reg;
        moving_next      = moving_reg;
        elapsed_ms_next  = elapsed_ms_reg;
        res_valid        = 1'b0;
        res_report       = spc_pkg::RPT_STOP;
        if (step) begin
            case (spc_pkg::action_t'(action))
                spc_pkg::ACT_TICK: begin
                    if (moving_reg) begin
                        elapsed_ms_next = elapsed_inc;
                        if (timed_out) begin
                            moving_next     = 1'b0;
                            elapsed_ms_next = '0;
                            res_valid       = 1'b1;
                        end
                    end
                end
                spc_pkg::ACT_UPDATE: begin
                    current_pos_next = pos_ext;
                    if (moving_reg && (pos_ext == target_pos_reg)) begin
                        moving_next     = 1'b0;
                        elapsed_ms_next = '0;
                        res_valid       = 1'b1;
                    end
                end
                spc_pkg::ACT_TARGET: begin
                    target_pos_next = clamped[PW-1:0];
                    if (direct != 0) begin
                        moving_next     = 1'b1;
                        elapsed_ms_next = '0;
                        res_valid       = 1'b1;
                        res_report      = go_up ? spc_pkg::RPT_UP : spc_pkg::RPT_DOWN;
                    end
                end
                spc_pkg::ACT_STOP: begin
                    moving_next     = 1'b0;
                    elapsed_ms_next = '0;
                    res_valid       = 1'b1;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_pos_reg <= '0;
            target_pos_reg  <= '0;
            moving_reg      <= 1'b0;
            elapsed_ms_reg  <= '0;
        end else begin
            current_pos_reg <= current_pos_next;
            target_pos_reg  <= target_pos_next;
            moving_reg      <= moving_next;
            elapsed_ms_reg  <= elapsed_ms_next;
        end
    end

    assign status.moving          = moving_reg;
    assign status.timer_saturated = timer_full;

endmodule

`default_nettype wire
